// ----- design/bcpa_pkg.sv -----
// Package for the bitmap contiguous page allocator.
// Holds the request and response word types and the shared field widths.
// No dependencies.
package bcpa_pkg;

   // Field widths
   localparam int HINT_W      = 12;
   localparam int COUNT_W     = 13;
   localparam int LIMIT_W     = 13;
   localparam int PAGE_W      = 13;
   localparam int WORD_BITS   = 32;
   localparam int BIT_W       = 5;
   localparam int WIDX_W      = PAGE_W - BIT_W;

   // Default store size and reset value of the page limit
   localparam int NUM_PAGES_DEFAULT = 4096;
   localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RESET = 13'd4096;

   // Request word: where to start and how many pages
   typedef struct packed {
      logic [HINT_W-1:0]  first_page_hint;
      logic [COUNT_W-1:0] page_count;
   } req_word_type;

   // Response word: grant flag and first page of the run
   typedef struct packed {
      logic              granted;
      logic [HINT_W-1:0] run_start;
   } rsp_word_type;

endpackage

// ----- design/bitmap_contiguous_page_allocator.sv -----
// Top level of the bitmap contiguous page allocator: bitmap store, scan
// sequencer and mark sequencer. Depends on bcpa_pkg.
//
// First-fit allocator of contiguous pages over a one-bit-per-page bitmap kept
// in a 32-bit-wide memory. After reset the block sweeps the memory to clear it,
// one word per cycle, and keeps busy high meanwhile; limit writes are taken at
// any time. A request is taken on start while busy is low. Requests that need
// no search (hint at or above the limit, count above the limit, zero count)
// answer in the cycle after start. Otherwise the scan reads the first word,
// then per bitmap word takes a load step, one step per free stretch inspected
// in that word, and one more step unless the last free stretch reaches the top
// bit; the scan state examines one free stretch at a time. A grant then marks
// the run with a setup step and a read/write pair per word it touches. The
// answer is on rsp_data for exactly one cycle with rsp_valid high and cannot
// be held off, so the receiver must capture it then.
module bitmap_contiguous_page_allocator
   import bcpa_pkg::*;
#(
   parameter int NUM_PAGES = NUM_PAGES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   // request side
   input  logic                start,
   output logic                busy,
   input  req_word_type        req_data,
   // response side
   output logic                rsp_valid,
   output rsp_word_type        rsp_data,
   // limit register write
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [LIMIT_W-1:0]  csr_data
);

   localparam int WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [LIMIT_W-1:0] LIM_CAP =
      (NUM_PAGES < 8192) ? LIMIT_W'(NUM_PAGES) : {LIMIT_W{1'b1}};
   localparam logic [WAW-1:0] LAST_ADDR = WAW'(WORDS - 1);
   localparam logic [WORD_BITS-1:0] ALL1 = {WORD_BITS{1'b1}};
   localparam logic [BIT_W:0] NONE_IDX = (BIT_W+1)'(WORD_BITS);

   // sequencer states
   localparam logic [2:0] ST_CLEAR     = 3'd0;
   localparam logic [2:0] ST_IDLE      = 3'd1;
   localparam logic [2:0] ST_RD        = 3'd2;
   localparam logic [2:0] ST_LOAD      = 3'd3;
   localparam logic [2:0] ST_SEG       = 3'd4;
   localparam logic [2:0] ST_MARK_INIT = 3'd5;
   localparam logic [2:0] ST_MARK_RD   = 3'd6;
   localparam logic [2:0] ST_MARK_WR   = 3'd7;

   // lowest set bit, WORD_BITS when none
   function automatic logic [BIT_W:0] first_set(input logic [WORD_BITS-1:0] v);
      logic [BIT_W:0] idx;
      idx = NONE_IDX;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = (BIT_W+1)'(i);
         end
      end
      return idx;
   endfunction

   // registers
   logic [2:0]            state_ff, state_in;
   logic [WAW-1:0]        clr_ff, clr_in;
   logic [LIMIT_W-1:0]    page_limit_ff, page_limit_in;
   logic [LIMIT_W-1:0]    lim_ff, lim_in;
   logic [HINT_W-1:0]     hint_ff, hint_in;
   logic [COUNT_W-1:0]    cnt_ff, cnt_in;
   logic [WIDX_W-1:0]     w_ff, w_in;
   logic [WORD_BITS-1:0]  blk_ff, blk_in;
   logic [BIT_W:0]        pos_ff, pos_in;
   logic [PAGE_W-1:0]     r_ff, r_in;
   logic [PAGE_W-1:0]     s_ff, s_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_data_ff, rsp_data_in;

   // bitmap store
   logic [WORD_BITS-1:0]  mem [WORDS];
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic                  mem_we, rd_en;
   logic [WAW-1:0]        wr_addr, rd_addr;
   logic [WORD_BITS-1:0]  wr_data;

   // scan and mark datapath
   logic [LIMIT_W-1:0]    lim_eff;
   logic [LIMIT_W-1:0]    lim_m1;
   logic [WIDX_W-1:0]     first_word, last_word;
   logic [WORD_BITS-1:0]  hint_mask, lim_mask;
   logic [BIT_W:0]        fs, fe, seg_len;
   logic [PAGE_W-1:0]     rr;
   logic [PAGE_W:0]       total;
   logic                  hit;
   logic [PAGE_W-1:0]     seg_start;
   logic [PAGE_W-1:0]     elast;
   logic [BIT_W-1:0]      mk_lo, mk_hi;
   logic [WORD_BITS-1:0]  mk_mask;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // effective limit at request time, and per-request bounds
   assign lim_eff    = (page_limit_ff < LIM_CAP) ? page_limit_ff : LIM_CAP;
   assign lim_m1     = lim_ff - LIMIT_W'(1);
   assign first_word = {1'b0, hint_ff[HINT_W-1:BIT_W]};
   assign last_word  = lim_m1[PAGE_W-1:BIT_W];

   // edge masks: pages below the hint and at/above the limit count as used
   assign hint_mask = (w_ff == first_word) ? ~(ALL1 << hint_ff[BIT_W-1:0]) : '0;
   assign lim_mask  = (w_ff == last_word) ?
                      ~(ALL1 >> (BIT_W'(WORD_BITS - 1) - lim_m1[BIT_W-1:0])) : '0;

   // free stretch in the working word: first free bit, then first used above it
   assign fs        = first_set(~blk_ff);
   assign fe        = first_set(blk_ff & (blk_ff + WORD_BITS'(1)));
   assign seg_len   = fe - fs;
   assign rr        = (fs == pos_ff) ? r_ff : '0;
   assign total     = {1'b0, rr} + (PAGE_W+1)'(seg_len);
   assign hit       = (fs != NONE_IDX) && (total >= (PAGE_W+1)'(cnt_ff));
   assign seg_start = {w_ff, BIT_W'(0)} + PAGE_W'(fs) - rr;

   // range mask for the word being marked
   assign elast   = s_ff + cnt_ff - PAGE_W'(1);
   assign mk_lo   = (w_ff == s_ff[PAGE_W-1:BIT_W]) ? s_ff[BIT_W-1:0] : '0;
   assign mk_hi   = (w_ff == elast[PAGE_W-1:BIT_W]) ? elast[BIT_W-1:0] :
                    BIT_W'(WORD_BITS - 1);
   assign mk_mask = (ALL1 << mk_lo) & (ALL1 >> (BIT_W'(WORD_BITS - 1) - mk_hi));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      page_limit_in = page_limit_ff;
      lim_in        = lim_ff;
      hint_in       = hint_ff;
      cnt_in        = cnt_ff;
      w_in          = w_ff;
      blk_in        = blk_ff;
      pos_in        = pos_ff;
      r_in          = r_ff;
      s_in          = s_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      wr_addr       = WAW'(w_ff);
      wr_data       = rd_data_ff | mk_mask;
      rd_en         = 1'b0;
      rd_addr       = WAW'(w_ff);

      if (csr_valid) begin
         page_limit_in = csr_data;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we  = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + WAW'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               hint_in = req_data.first_page_hint;
               cnt_in  = req_data.page_count;
               lim_in  = lim_eff;
               if (({1'b0, req_data.first_page_hint} >= lim_eff) ||
                   (req_data.page_count > lim_eff)) begin
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.granted   = 1'b0;
                  rsp_data_in.run_start = '0;
               end else if (req_data.page_count == '0) begin
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.granted   = 1'b1;
                  rsp_data_in.run_start = req_data.first_page_hint;
               end else begin
                  w_in     = {1'b0, req_data.first_page_hint[HINT_W-1:BIT_W]};
                  r_in     = '0;
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            rd_en    = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            blk_in   = rd_data_ff | hint_mask | lim_mask;
            pos_in   = '0;
            state_in = ST_SEG;
         end
         ST_SEG: begin
            if (hit) begin
               s_in     = seg_start;
               state_in = ST_MARK_INIT;
            end else if ((fs == NONE_IDX) || (fe == NONE_IDX)) begin
               // word exhausted; a run reaching the top bit carries over
               r_in = (fs == NONE_IDX) ? '0 : total[PAGE_W-1:0];
               if (w_ff == last_word) begin
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.granted   = 1'b0;
                  rsp_data_in.run_start = '0;
                  state_in              = ST_IDLE;
               end else begin
                  w_in     = w_ff + WIDX_W'(1);
                  rd_en    = 1'b1;
                  rd_addr  = WAW'(w_ff + WIDX_W'(1));
                  state_in = ST_LOAD;
               end
            end else begin
               // stretch too short: consume it and the used bit above it
               blk_in = blk_ff | ~(ALL1 << fe[BIT_W-1:0]);
               pos_in = fe;
               r_in   = total[PAGE_W-1:0];
            end
         end
         ST_MARK_INIT: begin
            w_in     = s_ff[PAGE_W-1:BIT_W];
            state_in = ST_MARK_RD;
         end
         ST_MARK_RD: begin
            rd_en    = 1'b1;
            state_in = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            mem_we = 1'b1;
            if (w_ff == elast[PAGE_W-1:BIT_W]) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.granted   = 1'b1;
               rsp_data_in.run_start = s_ff[HINT_W-1:0];
               state_in              = ST_IDLE;
            end else begin
               w_in     = w_ff + WIDX_W'(1);
               state_in = ST_MARK_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         page_limit_ff <= PAGE_LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         page_limit_ff <= page_limit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      lim_ff      <= lim_in;
      hint_ff     <= hint_in;
      cnt_ff      <= cnt_in;
      w_ff        <= w_in;
      blk_ff      <= blk_in;
      pos_ff      <= pos_in;
      r_ff        <= r_in;
      s_ff        <= s_in;
      rsp_data_ff <= rsp_data_in;
   end

   // bitmap memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

`ifndef SYNTHESIS
   // a response only follows a taken request or work in progress
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("response without a request in progress");

   // a refused request reports page zero
   a_refuse_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.granted) |-> (rsp_data.run_start == '0))
      else $error("refused request with nonzero run start");

   // an accepted request either answers at once or starts work
   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("request accepted but dropped");

   // the bitmap is never written while idle
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_we)
      else $error("bitmap write while idle");
`endif

endmodule
